// File: hdl/checksummed_frame_receiver_defines.svh
// Assertion macros shared by the checker.
`ifndef CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define CRX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crx check failed");

// next-cycle implication
`define CRX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crx check failed");

`endif

// File: hdl/crx_pkg.sv
`timescale 1ns / 1ps

package crx_pkg;

   localparam int CHANNELS = 4;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [7:0] START_BYTE = 8'hF0;
   localparam logic [7:0] END_BYTE   = 8'h0D;

   // header_count values
   localparam logic [3:0] HDR_IDLE      = 4'd0;
   localparam logic [3:0] HDR_KIND_IDX  = 4'd2;
   localparam logic [3:0] HDR_LENH_IDX  = 4'd13;
   localparam logic [3:0] HDR_LENL_IDX  = 4'd14;
   localparam logic [3:0] HDR_DONE      = 4'd15;

   // tail_count values
   localparam logic [1:0] TAIL_CSUM_HI = 2'd0;
   localparam logic [1:0] TAIL_CSUM_LO = 2'd1;

   // result status codes
   localparam logic [2:0] ST_IGNORED  = 3'd0;
   localparam logic [2:0] ST_HEADER   = 3'd1;
   localparam logic [2:0] ST_PAYLOAD  = 3'd2;
   localparam logic [2:0] ST_ACCEPTED = 3'd3;
   localparam logic [2:0] ST_REJECTED = 3'd4;
   localparam logic [2:0] ST_TOO_LONG = 3'd5;
   localparam logic [2:0] ST_ABORTED  = 3'd6;

   // input action codes
   localparam logic ACT_BYTE  = 1'b0;
   localparam logic ACT_ABORT = 1'b1;

   localparam int KIND_COUNT = 10;
   localparam logic [3:0] KIND_UNKNOWN   = 4'd9;
   localparam logic [3:0] KIND_HANDLED_LO = 4'd3;
   localparam logic [3:0] KIND_HANDLED_HI = 4'd5;
   localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

   localparam logic [7:0] TYPE_CODES [KIND_COUNT] = '{
      8'h10, 8'h20, 8'h30, 8'h50, 8'h52, 8'h54, 8'h60, 8'h62, 8'h64, 8'hFE
   };

   typedef struct packed {
      logic [3:0]  header_count;
      logic [1:0]  tail_count;
      logic [15:0] running_sum;
      logic [3:0]  kind_reg;
      logic [7:0]  length_high;
      logic [15:0] length_total;
      logic [15:0] remaining;
      logic [7:0]  tail_sum_high;
      logic [7:0]  tail_sum_low;
   } chan_state_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  frame_kind;
      logic [7:0]  payload_byte;
      logic        first_payload;
      logic [15:0] frame_length;
   } result_type;

   function automatic logic [3:0] lookup_kind(input logic [7:0] code);
      logic [3:0] k;
      k = KIND_UNKNOWN;
      for (int i = 0; i < KIND_COUNT; i++) begin
         if (TYPE_CODES[i] == code) begin
            k = 4'(i);
         end
      end
      return k;
   endfunction

endpackage

// File: hdl/crx_state_mem.sv
`timescale 1ns / 1ps

// Per-channel state store with a registered read. Entries never written read as zero.
module crx_state_mem (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [crx_pkg::CH_IDX_W-1:0]       rd_addr,
   output crx_pkg::chan_state_type            rd_data,
   input  logic                               wr_en,
   input  logic [crx_pkg::CH_IDX_W-1:0]       wr_addr,
   input  crx_pkg::chan_state_type            wr_data
);

   crx_pkg::chan_state_type mem_ff [crx_pkg::CHANNELS];
   crx_pkg::chan_state_type rd_data_ff;
   logic [crx_pkg::CHANNELS-1:0] vld_ff;
   logic                         rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// File: hdl/crx_frame_logic.sv
`timescale 1ns / 1ps

// Deframer next-state and result for one beat of one channel.
module crx_frame_logic (
   input  logic                     action,
   input  logic [7:0]               rx_byte,
   input  logic [15:0]              max_len,
   input  crx_pkg::chan_state_type  cur,
   output crx_pkg::chan_state_type  nxt,
   output crx_pkg::result_type      res
);

   logic [15:0] new_len;
   logic [15:0] csum_total;
   logic        kind_ok;
   logic [2:0]  status;
   logic [7:0]  pay;
   logic        first;

   assign new_len    = {cur.length_high, rx_byte};
   assign csum_total = {cur.tail_sum_high, cur.tail_sum_low} + cur.running_sum;
   assign kind_ok    = (cur.kind_reg >= crx_pkg::KIND_HANDLED_LO) &&
                       (cur.kind_reg <= crx_pkg::KIND_HANDLED_HI);

   always_comb begin
      nxt    = cur;
      status = crx_pkg::ST_IGNORED;
      pay    = 8'd0;
      first  = 1'b0;
      if (action == crx_pkg::ACT_ABORT) begin
         if (cur.header_count != crx_pkg::HDR_IDLE) begin
            nxt.header_count = crx_pkg::HDR_IDLE;
            status           = crx_pkg::ST_ABORTED;
         end
      end else if (cur.header_count == crx_pkg::HDR_IDLE) begin
         if (rx_byte == crx_pkg::START_BYTE) begin
            nxt.header_count = 4'd1;
            nxt.tail_count   = '0;
            nxt.running_sum  = '0;
            nxt.kind_reg     = '0;
            nxt.length_total = '0;
            nxt.remaining    = '0;
            status           = crx_pkg::ST_HEADER;
         end
      end else if (cur.header_count != crx_pkg::HDR_DONE) begin
         nxt.header_count = cur.header_count + 4'd1;
         nxt.running_sum  = cur.running_sum + 16'(rx_byte);
         status           = crx_pkg::ST_HEADER;
         case (cur.header_count)
            crx_pkg::HDR_KIND_IDX: begin
               nxt.kind_reg = crx_pkg::lookup_kind(rx_byte);
            end
            crx_pkg::HDR_LENH_IDX: begin
               nxt.length_high = rx_byte;
            end
            crx_pkg::HDR_LENL_IDX: begin
               nxt.length_total = new_len;
               nxt.remaining    = new_len;
               if (new_len > max_len) begin
                  nxt.header_count = crx_pkg::HDR_IDLE;
                  status           = crx_pkg::ST_TOO_LONG;
               end
            end
            default: begin
            end
         endcase
      end else if (cur.remaining != 16'd0) begin
         nxt.running_sum = cur.running_sum + 16'(rx_byte);
         nxt.remaining   = cur.remaining - 16'd1;
         first           = (cur.remaining == cur.length_total);
         pay             = rx_byte;
         status          = crx_pkg::ST_PAYLOAD;
      end else begin
         case (cur.tail_count)
            crx_pkg::TAIL_CSUM_HI: begin
               nxt.tail_sum_high = rx_byte;
               nxt.tail_count    = 2'd1;
               status            = crx_pkg::ST_HEADER;
            end
            crx_pkg::TAIL_CSUM_LO: begin
               nxt.tail_sum_low = rx_byte;
               nxt.tail_count   = 2'd2;
               status           = crx_pkg::ST_HEADER;
            end
            default: begin
               // terminator position
               nxt.tail_count   = '0;
               nxt.header_count = crx_pkg::HDR_IDLE;
               status = (rx_byte == crx_pkg::END_BYTE && kind_ok && csum_total == 16'd0)
                        ? crx_pkg::ST_ACCEPTED : crx_pkg::ST_REJECTED;
            end
         endcase
      end
   end

   assign res.status        = status;
   assign res.frame_kind    = nxt.kind_reg;
   assign res.payload_byte  = pay;
   assign res.first_payload = first;
   assign res.frame_length  = nxt.length_total;

endmodule

// File: hdl/checksummed_frame_receiver.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Beat contents
// req_      | in        | req_valid/stall    | action, channel, rx_byte
// rsp_      | out       | rsp_valid/stall    | out_channel, status, kind, payload, first, length
// csr_      | in        | csr_wr_en          | max_data_length (16 bit)
//
// One beat per clock while rsp_stall is low; every request beat yields one response beat.
// The request accept edge launches the state memory read and loads the update stage; the
// deframer update is registered into the response register when the update stage advances.
// Reset clears control and the per-entry valid bits at once; no clearing pass.
// A stalled response holds the update stage, which in turn stalls the request side.
module checksummed_frame_receiver (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [1:0]  req_channel,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_channel,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_frame_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_first_payload,
   output logic [15:0] rsp_frame_length,

   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int CW = crx_pkg::CH_IDX_W;

   // config register
   logic [15:0] max_len_ff;

   // update stage (item whose state read is in flight / returned)
   logic        s1_vld_ff;
   logic        s1_vld_in;
   logic        s1_action_ff;
   logic [1:0]  s1_channel_ff;
   logic [7:0]  s1_byte_ff;

   // forwarding of a write that lands on the same edge as the read
   logic                    fwd_hit_ff;
   logic                    fwd_hit_in;
   crx_pkg::chan_state_type fwd_data_ff;

   // response register
   logic               rsp_vld_ff;
   logic               rsp_vld_in;
   logic [1:0]         rsp_channel_ff;
   crx_pkg::result_type rsp_res_ff;
   crx_pkg::result_type rsp_res_in;

   logic                    accept;
   logic                    s1_adv;
   logic                    ch_ok;
   logic [CW-1:0]           rd_addr;
   logic [CW-1:0]           wr_addr;
   logic                    wr_en;
   crx_pkg::chan_state_type mem_rd_data;
   crx_pkg::chan_state_type cur_state;
   crx_pkg::chan_state_type nxt_state;
   crx_pkg::result_type     calc_res;

   // ---------------------------------------------------------------- handshake
   // Update stage moves on when the response register is empty or draining.
   assign s1_adv    = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;
   assign s1_vld_in = accept || (s1_vld_ff && !s1_adv);
   assign rsp_vld_in = s1_adv || (rsp_vld_ff && rsp_stall);

   // ---------------------------------------------------------------- state memory
   assign rd_addr = CW'(req_channel);
   assign wr_addr = CW'(s1_channel_ff);
   assign ch_ok   = 32'(s1_channel_ff) < crx_pkg::CHANNELS;
   assign wr_en   = s1_adv && ch_ok;

   crx_state_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (nxt_state)
   );

   // Read-before-write memory: a back-to-back beat on the same channel sees
   // stale data, so the write issued alongside its read is captured here.
   assign fwd_hit_in = wr_en && (wr_addr == rd_addr);
   assign cur_state  = fwd_hit_ff ? fwd_data_ff : mem_rd_data;

   // ---------------------------------------------------------------- deframer
   crx_frame_logic u_logic (
      .action  (s1_action_ff),
      .rx_byte (s1_byte_ff),
      .max_len (max_len_ff),
      .cur     (cur_state),
      .nxt     (nxt_state),
      .res     (calc_res)
   );

   // out-of-range channel: ignored, fields cleared
   always_comb begin
      rsp_res_in = calc_res;
      if (!ch_ok) begin
         rsp_res_in = '0;
         rsp_res_in.status = crx_pkg::ST_IGNORED;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= crx_pkg::MAX_LEN_RESET;
         s1_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (accept) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff  <= req_action;
         s1_channel_ff <= req_channel;
         s1_byte_ff    <= req_rx_byte;
         fwd_data_ff   <= nxt_state;
      end
      if (s1_adv) begin
         rsp_channel_ff <= s1_channel_ff;
         rsp_res_ff     <= rsp_res_in;
      end
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid         = rsp_vld_ff;
   assign rsp_out_channel   = rsp_channel_ff;
   assign rsp_status        = rsp_res_ff.status;
   assign rsp_frame_kind    = rsp_res_ff.frame_kind;
   assign rsp_payload_byte  = rsp_res_ff.payload_byte;
   assign rsp_first_payload = rsp_res_ff.first_payload;
   assign rsp_frame_length  = rsp_res_ff.frame_length;

endmodule

// File: hdl/crx_checker.sv
`timescale 1ns / 1ps
`include "checksummed_frame_receiver_defines.svh"

module crx_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_out_channel,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_first_payload,
   input logic [15:0] rsp_frame_length
);

   // stalled response beat holds
   `CRX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_payload_byte) && $stable(rsp_out_channel))

   // payload byte only on payload beats
   `CRX_ASSERT_NOW(a_pay_only, clock, reset, rsp_valid && rsp_status != crx_pkg::ST_PAYLOAD, rsp_payload_byte == 8'd0 && !rsp_first_payload)

   // first-byte flag implies a nonempty payload beat
   `CRX_ASSERT_NOW(a_first_len, clock, reset, rsp_valid && rsp_first_payload, rsp_status == crx_pkg::ST_PAYLOAD && rsp_frame_length != 16'd0)

   // a dropped frame carries a length above some limit, so never zero
   `CRX_ASSERT_NOW(a_too_long, clock, reset, rsp_valid && rsp_status == crx_pkg::ST_TOO_LONG, rsp_frame_length != 16'd0)

endmodule

bind checksummed_frame_receiver crx_checker u_crx_checker (.*);
